// ===== rtl/shift_rotate_unit_with_flags_top_assert.svh =====
// Assertion macros for the shift/rotate unit checker.
// Depends on nothing; included by the checker file.
`ifndef SHIFT_ROTATE_UNIT_WITH_FLAGS_TOP_ASSERT_SVH
`define SHIFT_ROTATE_UNIT_WITH_FLAGS_TOP_ASSERT_SVH

// Check a property on every edge outside reset.
`define SRU_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every edge, reset included.
`define SRU_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/sru_pkg.sv =====
// Shared types, codes and helper functions for the shift/rotate unit.
// No dependencies; used by sru_step and the top level.
package sru_pkg;

  localparam int DataW = 32;
  localparam int CountW = 6;
  localparam int KindW = 3;
  localparam int SizeW = 2;
  localparam int InTdataW = 48;
  localparam int OutTdataW = 40;
  localparam int OutFieldW = DataW + 5;

  // Request kinds
  localparam logic [KindW-1:0] KIND_ASR  = 3'd0;
  localparam logic [KindW-1:0] KIND_ASL  = 3'd1;
  localparam logic [KindW-1:0] KIND_LSR  = 3'd2;
  localparam logic [KindW-1:0] KIND_LSL  = 3'd3;
  localparam logic [KindW-1:0] KIND_ROXR = 3'd4;
  localparam logic [KindW-1:0] KIND_ROXL = 3'd5;
  localparam logic [KindW-1:0] KIND_ROR  = 3'd6;
  localparam logic [KindW-1:0] KIND_ROL  = 3'd7;

  // Operand sizes; the unused codes behave as long
  localparam logic [SizeW-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SizeW-1:0] SIZE_WORD = 2'd1;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             out_bit;
    logic             sign_chg;
  } step_out_t;

  function automatic logic [DataW-1:0] operand_mask(input logic [SizeW-1:0] size);
    logic [DataW-1:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_WORD: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // One-hot mask of the sized operand's sign bit
  function automatic logic [DataW-1:0] size_top(input logic [SizeW-1:0] size);
    logic [DataW-1:0] t;
    case (size)
      SIZE_BYTE: t = 32'h0000_0080;
      SIZE_WORD: t = 32'h0000_8000;
      default:   t = 32'h8000_0000;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/shift_rotate_unit_with_flags_top.sv =====
// Top level of the shift/rotate unit: stream ports, sequencer, output register.
// Depends on sru_pkg and sru_step.
//
// The unit runs one ASR/ASL/LSR/LSL/ROXR/ROXL/ROR/ROL request on the low byte,
// word or long of a 32-bit register value and returns the new register value
// with the bits above the operand size kept, plus N, Z, V, C and X. A single
// one-position shift step is reused once per cycle for each of the shift_count
// positions, and then the result is loaded into the output register; the input
// side is ready again only when that load happens, so a new request is not
// accepted before the previous one's result is in the output register. The
// result register frees the datapath from the consumer: a finished result
// waits there while a new request is accepted and shifted, and the sequencer
// stalls only if a second result is ready before the first one has been
// taken. Size code three acts as long. A count of zero leaves the value and X
// unchanged and sets C to X for ROXL/ROXR, to zero otherwise. V is only set by
// ASL, when the sign bit changes at any step of the shift.
module shift_rotate_unit_with_flags_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [2:0] req_type, [4:3] operand_size, [10:5] shift_count,
  // [42:11] operand_value, [43] x_in, [47:44] zero
  input  logic [sru_pkg::InTdataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] result_value, [32] flag_n, [33] flag_z, [34] flag_v,
  // [35] flag_c, [36] flag_x, [39:37] zero
  output logic [sru_pkg::OutTdataW-1:0] m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Request held while it is being shifted
  logic [sru_pkg::KindW-1:0]  kind;
  logic [sru_pkg::SizeW-1:0]  size;
  logic [sru_pkg::CountW-1:0] cnt_left;
  logic [sru_pkg::DataW-1:0]  work;
  logic [sru_pkg::DataW-1:0]  full;
  logic                       x_orig;
  logic                       x_ring;
  logic                       carry;
  logic                       v_acc;
  logic                       cnt_zero;

  logic [sru_pkg::OutFieldW-1:0] out_data;

  sru_pkg::step_out_t step;

  logic in_xfer;
  logic finish;
  logic is_rox;
  logic is_rot;
  logic [sru_pkg::DataW-1:0] mask;
  logic [sru_pkg::DataW-1:0] top;
  logic [sru_pkg::DataW-1:0] res_full;
  logic flag_n;
  logic flag_z;
  logic flag_c;
  logic flag_x;

  sru_step u_step (
    .kind  (kind),
    .size  (size),
    .value (work),
    .x_bit (x_ring),
    .step  (step)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  // Load the result once all steps are done and the output slot is free
  assign finish   = (state == ST_RUN) && (cnt_left == '0) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_xfer) state_next = ST_RUN;
      ST_RUN:  if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request, then advance one position per cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind     <= s_tdata[2:0];
      size     <= s_tdata[4:3];
      cnt_left <= s_tdata[10:5];
      cnt_zero <= (s_tdata[10:5] == '0);
      full     <= s_tdata[42:11];
      work     <= s_tdata[42:11] & sru_pkg::operand_mask(s_tdata[4:3]);
      x_orig   <= s_tdata[43];
      x_ring   <= s_tdata[43];
      carry    <= 1'b0;
      v_acc    <= 1'b0;
    end else if ((state == ST_RUN) && (cnt_left != '0)) begin
      cnt_left <= cnt_left - 1'b1;
      work     <= step.value;
      x_ring   <= step.out_bit;
      carry    <= step.out_bit;
      v_acc    <= v_acc | step.sign_chg;
    end
  end

  // Assemble the result and flags from the finished work register
  always_comb begin
    mask     = sru_pkg::operand_mask(size);
    top      = sru_pkg::size_top(size);
    is_rox   = (kind == sru_pkg::KIND_ROXR) || (kind == sru_pkg::KIND_ROXL);
    is_rot   = (kind == sru_pkg::KIND_ROR) || (kind == sru_pkg::KIND_ROL);
    res_full = (full & ~mask) | work;
    flag_n   = |(work & top);
    flag_z   = (work == '0);
    flag_c   = cnt_zero ? (is_rox ? x_orig : 1'b0) : carry;
    flag_x   = (cnt_zero || is_rot) ? x_orig : carry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= {flag_x, flag_c, v_acc, flag_z, flag_n, res_full};
    end
  end

  assign m_tdata = {{(sru_pkg::OutTdataW - sru_pkg::OutFieldW){1'b0}}, out_data};

endmodule

// ===== rtl/sru_step.sv =====
// One-position shift/rotate step on the sized operand, shared by every kind.
// Depends on sru_pkg.
module sru_step (
  input  logic [sru_pkg::KindW-1:0] kind,
  input  logic [sru_pkg::SizeW-1:0] size,
  input  logic [sru_pkg::DataW-1:0] value,
  input  logic                      x_bit,
  output sru_pkg::step_out_t        step
);

  logic [sru_pkg::DataW-1:0] mask;
  logic [sru_pkg::DataW-1:0] top;
  logic [sru_pkg::DataW-1:0] shl;
  logic [sru_pkg::DataW-1:0] shr;
  logic [sru_pkg::DataW-1:0] nv;
  logic msb;
  logic msb_new;
  logic lsb;
  logic left;
  logic fill;

  always_comb begin
    mask = sru_pkg::operand_mask(size);
    top  = sru_pkg::size_top(size);
    msb  = |(value & top);
    lsb  = value[0];
    case (kind)
      sru_pkg::KIND_ASR:  begin left = 1'b0; fill = msb;   end
      sru_pkg::KIND_ASL:  begin left = 1'b1; fill = 1'b0;  end
      sru_pkg::KIND_LSR:  begin left = 1'b0; fill = 1'b0;  end
      sru_pkg::KIND_LSL:  begin left = 1'b1; fill = 1'b0;  end
      sru_pkg::KIND_ROXR: begin left = 1'b0; fill = x_bit; end
      sru_pkg::KIND_ROXL: begin left = 1'b1; fill = x_bit; end
      sru_pkg::KIND_ROR:  begin left = 1'b0; fill = lsb;   end
      default:            begin left = 1'b1; fill = msb;   end
    endcase
    shl = ((value << 1) | {{(sru_pkg::DataW-1){1'b0}}, fill}) & mask;
    shr = (value >> 1) | (fill ? top : '0);
    nv  = left ? shl : shr;
    msb_new = |(nv & top);
    step.value    = nv;
    step.out_bit  = left ? msb : lsb;
    step.sign_chg = (kind == sru_pkg::KIND_ASL) && (msb_new != msb);
  end

endmodule

// ===== rtl/sru_checker.sv =====
// Port-level checker for the shift/rotate unit, bound to the top level.
// Depends on shift_rotate_unit_with_flags_top_assert.svh and sru_pkg.
`include "shift_rotate_unit_with_flags_top_assert.svh"

module sru_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [sru_pkg::InTdataW-1:0]  s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sru_pkg::OutTdataW-1:0] m_tdata
);

  // A stalled result holds its value
  `SRU_ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // The unit works on one request at a time: busy right after a transfer
  `SRU_ASSERT_CLK(a_busy_after_in, clk, rst, s_tvalid && s_tready |=> !s_tready)

  // Reset leaves the unit ready with no result pending
  `SRU_ASSERT_ALL(a_reset_state, clk, rst |=> s_tready && !m_tvalid)

  // A new result appears only as the unit goes from busy back to idle
  `SRU_ASSERT_CLK(a_no_spurious_out, clk, rst, $rose(m_tvalid) |-> s_tready && !$past(s_tready))

endmodule

bind shift_rotate_unit_with_flags_top sru_checker u_sru_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
